// ----- hdl/gdad_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdad_pkg: shared types and constants for the Gregorian date adder
// Holds field widths, limits, the controller state type, the command and
// status bundles between controller and datapath, and the calendar tables.
// ----------------------------------------------------------------------------
package gdad_pkg;

  localparam int unsigned DAY_COUNT_BITS = 20;
  localparam int unsigned MAX_YEAR       = 9999;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned COUNT_W = 20;
  localparam int unsigned DOY_W   = 9;

  // Only the low DAY_COUNT_BITS bits of the count take part.
  localparam logic [COUNT_W-1:0] COUNT_MASK =
    COUNT_W'((64'd1 << DAY_COUNT_BITS) - 64'd1);

  localparam logic [YEAR_W-1:0]  CYCLE_YEARS = YEAR_W'(400);
  localparam logic [MONTH_W-1:0] JANUARY     = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] FEBRUARY    = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] DECEMBER    = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   LAST_DAY    = DAY_W'(31);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_CLAMP,
    ST_PLAN,
    ST_YEARS,
    ST_DAYS,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic clamp;
    logic skip_rest;
    logic year_step;
    logic day_step;
    logic saturate;
  } cmd_t;

  typedef struct packed {
    logic mod_ge_cycle;
    logic year_over_max;
    logic year_at_max;
    logic count_ge_rest;
    logic count_ge_next;
    logic count_zero;
  } status_t;

  // Days in a month of a year with the given leap flag; month is 1..12.
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    unique case (month)
      4'd2:                      len = leap ? DAY_W'(29) : DAY_W'(28);
      4'd4, 4'd6, 4'd9, 4'd11:   len = DAY_W'(30);
      default:                   len = DAY_W'(31);
    endcase
    return len;
  endfunction

  // Days of a common year that lie before the first day of the month.
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] month);
    logic [DOY_W-1:0] sum;
    unique case (month)
      4'd2:    sum = DOY_W'(31);
      4'd3:    sum = DOY_W'(59);
      4'd4:    sum = DOY_W'(90);
      4'd5:    sum = DOY_W'(120);
      4'd6:    sum = DOY_W'(151);
      4'd7:    sum = DOY_W'(181);
      4'd8:    sum = DOY_W'(212);
      4'd9:    sum = DOY_W'(243);
      4'd10:   sum = DOY_W'(273);
      4'd11:   sum = DOY_W'(304);
      4'd12:   sum = DOY_W'(334);
      default: sum = DOY_W'(0);
    endcase
    return sum;
  endfunction

  // Leap flag from the year's position in the 400-year cycle.
  function automatic logic cycle_leap(input logic [YEAR_W-1:0] pos);
    return (pos[1:0] == 2'b00) && (pos != YEAR_W'(100)) && (pos != YEAR_W'(200))
           && (pos != YEAR_W'(300));
  endfunction

endpackage

// ----- hdl/gdad_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdad_ctrl: sequencer of the Gregorian date adder
// Walks the datapath through cycle reduction, clamping, the jump to year end,
// whole-year skipping and single-day stepping or saturation, then strobes the result.
// ----------------------------------------------------------------------------
module gdad_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  gdad_pkg::status_t status,
  output gdad_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              out_valid
);

  gdad_pkg::state_t state_r;
  gdad_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gdad_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gdad_pkg::ST_IDLE: begin
        if (start) state_nxt = gdad_pkg::ST_MOD;
      end
      gdad_pkg::ST_MOD: begin
        if (!status.mod_ge_cycle) state_nxt = gdad_pkg::ST_CLAMP;
      end
      gdad_pkg::ST_CLAMP: begin
        state_nxt = gdad_pkg::ST_PLAN;
      end
      gdad_pkg::ST_PLAN: begin
        priority if (status.year_over_max) state_nxt = gdad_pkg::ST_DONE;
        else if (status.count_ge_rest)     state_nxt = gdad_pkg::ST_YEARS;
        else                               state_nxt = gdad_pkg::ST_DAYS;
      end
      gdad_pkg::ST_YEARS: begin
        priority if (status.count_ge_next) begin
          if (status.year_at_max) state_nxt = gdad_pkg::ST_DONE;
        end else if (!status.count_zero && status.year_at_max) begin
          state_nxt = gdad_pkg::ST_DONE;
        end else begin
          state_nxt = gdad_pkg::ST_DAYS;
        end
      end
      gdad_pkg::ST_DAYS: begin
        if (status.count_zero) state_nxt = gdad_pkg::ST_DONE;
      end
      gdad_pkg::ST_DONE: begin
        state_nxt = gdad_pkg::ST_IDLE;
      end
      default: state_nxt = gdad_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = (state_r != gdad_pkg::ST_IDLE);
    out_valid = (state_r == gdad_pkg::ST_DONE);
    unique case (state_r)
      gdad_pkg::ST_IDLE:  cmd.load     = start;
      gdad_pkg::ST_MOD:   cmd.mod_step = status.mod_ge_cycle;
      gdad_pkg::ST_CLAMP: cmd.clamp    = 1'b1;
      gdad_pkg::ST_PLAN: begin
        priority if (status.year_over_max) cmd.saturate  = 1'b1;
        else if (status.count_ge_rest)     cmd.skip_rest = 1'b1;
      end
      gdad_pkg::ST_YEARS: begin
        priority if (status.count_ge_next) begin
          if (status.year_at_max) cmd.saturate = 1'b1;
          else                    cmd.year_step = 1'b1;
        end else if (!status.count_zero && status.year_at_max) begin
          cmd.saturate = 1'b1;
        end
      end
      gdad_pkg::ST_DAYS: cmd.day_step = !status.count_zero;
      gdad_pkg::ST_DONE: cmd = '0;
      default:           cmd = '0;
    endcase
  end

endmodule

// ----- hdl/gdad_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdad_datapath: date registers and arithmetic of the Gregorian date adder
// Holds year, month, day, remaining count and the year's place in the
// 400-year cycle, and carries out one command from the sequencer per cycle.
// ----------------------------------------------------------------------------
module gdad_datapath (
  input  logic                                clk,
  input  gdad_pkg::cmd_t                      cmd,
  input  logic [gdad_pkg::YEAR_W-1:0]         in_start_year,
  input  logic [gdad_pkg::MONTH_W-1:0]        in_start_month,
  input  logic [gdad_pkg::DAY_W-1:0]          in_start_day,
  input  logic [gdad_pkg::COUNT_W-1:0]        in_days_to_add,
  output gdad_pkg::status_t                   status,
  output logic [gdad_pkg::YEAR_W-1:0]         year,
  output logic [gdad_pkg::MONTH_W-1:0]        month,
  output logic [gdad_pkg::DAY_W-1:0]          day,
  output logic                                overflow
);

  logic [gdad_pkg::YEAR_W-1:0]  year_r;
  logic [gdad_pkg::MONTH_W-1:0] month_r;
  logic [gdad_pkg::DAY_W-1:0]   day_r;
  logic [gdad_pkg::COUNT_W-1:0] count_r;
  logic [gdad_pkg::YEAR_W-1:0]  cyc_r;
  logic                         ovf_r;

  logic                         leap_cur;
  logic                         leap_next;
  logic [gdad_pkg::YEAR_W-1:0]  cyc_next;
  logic [gdad_pkg::DOY_W-1:0]   len_next;
  logic [gdad_pkg::DOY_W-1:0]   day_of_year;
  logic [gdad_pkg::DOY_W-1:0]   rest;
  logic [gdad_pkg::DAY_W-1:0]   cur_month_len;
  logic [gdad_pkg::MONTH_W-1:0] month_clamped;
  logic [gdad_pkg::DAY_W-1:0]   clamp_month_len;
  logic [gdad_pkg::DAY_W-1:0]   day_clamped;
  logic [31:0]                  year_ext;

  function automatic logic in_range_low(input logic [gdad_pkg::MONTH_W-1:0] mon);
    return mon == '0;
  endfunction

  // After the reduction pass, cyc_r tracks the year modulo 400.
  assign leap_cur  = gdad_pkg::cycle_leap(cyc_r);
  assign cyc_next  = (cyc_r == gdad_pkg::CYCLE_YEARS - 1'b1) ? '0 : cyc_r + 1'b1;
  assign leap_next = gdad_pkg::cycle_leap(cyc_next);
  assign len_next  = gdad_pkg::DOY_W'(365) + gdad_pkg::DOY_W'(leap_next);

  assign month_clamped = (in_range_low(month_r)) ? gdad_pkg::JANUARY
                       : (month_r > gdad_pkg::DECEMBER) ? gdad_pkg::DECEMBER : month_r;
  assign clamp_month_len = gdad_pkg::month_days(month_clamped, leap_cur);
  assign day_clamped = (day_r == '0) ? gdad_pkg::DAY_W'(1)
                     : (day_r > clamp_month_len) ? clamp_month_len : day_r;

  assign day_of_year = gdad_pkg::days_before(month_r)
                     + gdad_pkg::DOY_W'(leap_cur && (month_r > gdad_pkg::FEBRUARY))
                     + gdad_pkg::DOY_W'(day_r);
  assign rest = gdad_pkg::DOY_W'(365) + gdad_pkg::DOY_W'(leap_cur) - day_of_year;

  assign cur_month_len = gdad_pkg::month_days(month_r, leap_cur);
  assign year_ext      = {{(32 - gdad_pkg::YEAR_W){1'b0}}, year_r};

  always_comb begin
    status.mod_ge_cycle  = (cyc_r >= gdad_pkg::CYCLE_YEARS);
    status.year_over_max = (year_ext > gdad_pkg::MAX_YEAR);
    status.year_at_max   = (year_ext >= gdad_pkg::MAX_YEAR);
    status.count_ge_rest = (count_r >= gdad_pkg::COUNT_W'(rest));
    status.count_ge_next = (count_r >= gdad_pkg::COUNT_W'(len_next));
    status.count_zero    = (count_r == '0);
  end

  always_ff @(posedge clk) begin
    priority if (cmd.load) begin
      year_r  <= in_start_year;
      month_r <= in_start_month;
      day_r   <= in_start_day;
      count_r <= in_days_to_add & gdad_pkg::COUNT_MASK;
      cyc_r   <= in_start_year;
      ovf_r   <= 1'b0;
    end else if (cmd.mod_step) begin
      cyc_r <= cyc_r - gdad_pkg::CYCLE_YEARS;
    end else if (cmd.clamp) begin
      month_r <= month_clamped;
      day_r   <= day_clamped;
    end else if (cmd.skip_rest) begin
      count_r <= count_r - gdad_pkg::COUNT_W'(rest);
      month_r <= gdad_pkg::DECEMBER;
      day_r   <= gdad_pkg::LAST_DAY;
    end else if (cmd.year_step) begin
      year_r  <= year_r + 1'b1;
      cyc_r   <= cyc_next;
      count_r <= count_r - gdad_pkg::COUNT_W'(len_next);
    end else if (cmd.day_step) begin
      count_r <= count_r - 1'b1;
      if (day_r >= cur_month_len) begin
        day_r <= gdad_pkg::DAY_W'(1);
        if (month_r == gdad_pkg::DECEMBER) begin
          month_r <= gdad_pkg::JANUARY;
          year_r  <= year_r + 1'b1;
          cyc_r   <= cyc_next;
        end else begin
          month_r <= month_r + 1'b1;
        end
      end else begin
        day_r <= day_r + 1'b1;
      end
    end else if (cmd.saturate) begin
      year_r  <= gdad_pkg::YEAR_W'(gdad_pkg::MAX_YEAR);
      month_r <= gdad_pkg::DECEMBER;
      day_r   <= gdad_pkg::LAST_DAY;
      ovf_r   <= 1'b1;
    end
  end

  assign year     = year_r;
  assign month    = month_r;
  assign day      = day_r;
  assign overflow = ovf_r;

endmodule

// ----- hdl/gregorian_date_add_days_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_add_days_top: Gregorian date plus a day count
// Takes a date and a number of days and returns the date that many days
// later, saturating to the last day of the maximum year with an overflow flag.
// ----------------------------------------------------------------------------
// A date is taken when start is high while busy is low; busy then stays high
// until the result has been shown. The result appears on the out_ ports for
// exactly one cycle with out_valid high, and the receiver must take it in that
// cycle since it cannot hold the block off. One item first reduces the year to
// its place in the 400-year cycle, then clamps the fields and plans the walk;
// when the count reaches the end of the starting year it jumps to December 31
// and skips whole years, then it steps the remaining single days. A new date
// is not taken until the result has been shown. The year-skip loop and the
// day-step loop advance one year or one day per cycle.
module gregorian_date_add_days_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [gdad_pkg::YEAR_W-1:0]         in_start_year,
  input  logic [gdad_pkg::MONTH_W-1:0]        in_start_month,
  input  logic [gdad_pkg::DAY_W-1:0]          in_start_day,
  input  logic [gdad_pkg::COUNT_W-1:0]        in_days_to_add,
  output logic                                out_valid,
  output logic [gdad_pkg::YEAR_W-1:0]         out_result_year,
  output logic [gdad_pkg::MONTH_W-1:0]        out_result_month,
  output logic [gdad_pkg::DAY_W-1:0]          out_result_day,
  output logic                                out_overflow
);

  gdad_pkg::cmd_t    cmd;
  gdad_pkg::status_t status;

  gdad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  gdad_datapath u_datapath (
    .clk            (clk),
    .cmd            (cmd),
    .in_start_year  (in_start_year),
    .in_start_month (in_start_month),
    .in_start_day   (in_start_day),
    .in_days_to_add (in_days_to_add),
    .status         (status),
    .year           (out_result_year),
    .month          (out_result_month),
    .day            (out_result_day),
    .overflow       (out_overflow)
  );

endmodule

// ----- verif/gregorian_date_add_days_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_add_days_top_test: self-checking bench for the date adder
// Sends dates and day counts through the start/busy command port and checks
// each out_valid strobe against a calendar predictor in the bench. Covers
// clamped months and days, leap and century years, year-end crossings,
// saturation at the last year and raw out-of-range fields.
// ----------------------------------------------------------------------------
module gregorian_date_add_days_top_test;

  localparam int unsigned CYCLE_LIMIT  = 2_500_000;
  localparam int unsigned DRAIN_CYCLES = 3_500;
  localparam int unsigned PRINT_CAP    = 100;

  typedef struct packed {
    logic [gdad_pkg::YEAR_W-1:0]  year;
    logic [gdad_pkg::MONTH_W-1:0] month;
    logic [gdad_pkg::DAY_W-1:0]   day;
    logic                         overflow;
  } date_t;

  typedef struct {
    logic [gdad_pkg::YEAR_W-1:0]  year;
    logic [gdad_pkg::MONTH_W-1:0] month;
    logic [gdad_pkg::DAY_W-1:0]   day;
    logic [gdad_pkg::COUNT_W-1:0] count;
    date_t                        sum;
  } date_sum_t;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic [gdad_pkg::YEAR_W-1:0]  in_start_year;
  logic [gdad_pkg::MONTH_W-1:0] in_start_month;
  logic [gdad_pkg::DAY_W-1:0]   in_start_day;
  logic [gdad_pkg::COUNT_W-1:0] in_days_to_add;
  logic                         out_valid;
  logic [gdad_pkg::YEAR_W-1:0]  out_result_year;
  logic [gdad_pkg::MONTH_W-1:0] out_result_month;
  logic [gdad_pkg::DAY_W-1:0]   out_result_day;
  logic                         out_overflow;

  date_sum_t   due_dates[$];
  int unsigned dates_sent;
  int unsigned dates_checked;
  int unsigned overflow_seen;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          back_to_back;

  gregorian_date_add_days_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_start_year    (in_start_year),
    .in_start_month   (in_start_month),
    .in_start_day     (in_start_day),
    .in_days_to_add   (in_days_to_add),
    .out_valid        (out_valid),
    .out_result_year  (out_result_year),
    .out_result_month (out_result_month),
    .out_result_day   (out_result_day),
    .out_overflow     (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------
  function automatic bit is_leap_year(input int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned year_length(input int unsigned y);
    return is_leap_year(y) ? 366 : 365;
  endfunction

  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    int unsigned len;
    case (m)
      2:            len = is_leap_year(y) ? 29 : 28;
      4, 6, 9, 11:  len = 30;
      default:      len = 31;
    endcase
    return len;
  endfunction

  // Day number within the year, January 1 being day 1; month and day in range.
  function automatic int unsigned day_of_year(input int unsigned y, input int unsigned m,
                                              input int unsigned d);
    int unsigned doy;
    int unsigned mm;
    doy = d;
    for (mm = gdad_pkg::JANUARY; mm < m; mm++)
      doy += month_length(y, mm);
    return doy;
  endfunction

  function automatic date_t advance_date(input logic [gdad_pkg::YEAR_W-1:0] year_in,
                                         input logic [gdad_pkg::MONTH_W-1:0] month_in,
                                         input logic [gdad_pkg::DAY_W-1:0] day_in,
                                         input logic [gdad_pkg::COUNT_W-1:0] count_in);
    date_t       res;
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned n;
    int unsigned left;
    bit          ovf;
    y   = year_in;
    m   = month_in;
    d   = day_in;
    n   = count_in & gdad_pkg::COUNT_MASK;
    ovf = 1'b0;

    if (m < gdad_pkg::JANUARY) m = gdad_pkg::JANUARY;
    if (m > gdad_pkg::DECEMBER) m = gdad_pkg::DECEMBER;
    if (d < 1) d = 1;
    if (d > month_length(y, m)) d = month_length(y, m);

    if (y > gdad_pkg::MAX_YEAR) begin
      ovf = 1'b1;
    end else begin
      left = year_length(y) - day_of_year(y, m, d);
      if (n >= left) begin
        // Jump to December 31, then skip whole years while the count covers them.
        n -= left;
        m = gdad_pkg::DECEMBER;
        d = gdad_pkg::LAST_DAY;
        while (!ovf && n >= year_length(y + 1)) begin
          if (y + 1 > gdad_pkg::MAX_YEAR) begin
            ovf = 1'b1;
          end else begin
            y++;
            n -= year_length(y);
          end
        end
        if (!ovf && n > 0 && y + 1 > gdad_pkg::MAX_YEAR) ovf = 1'b1;
      end
      if (!ovf) begin
        while (n > 0) begin
          if (d >= month_length(y, m)) begin
            d = 1;
            if (m == gdad_pkg::DECEMBER) begin
              m = gdad_pkg::JANUARY;
              y++;
            end else begin
              m++;
            end
          end else begin
            d++;
          end
          n--;
        end
      end
    end

    if (ovf) begin
      y = gdad_pkg::MAX_YEAR;
      m = gdad_pkg::DECEMBER;
      d = gdad_pkg::LAST_DAY;
    end
    res.year     = y[gdad_pkg::YEAR_W-1:0];
    res.month    = m[gdad_pkg::MONTH_W-1:0];
    res.day      = d[gdad_pkg::DAY_W-1:0];
    res.overflow = ovf;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Drives one date and holds start until the block takes it.
  task automatic send_date(input logic [gdad_pkg::YEAR_W-1:0] year,
                           input logic [gdad_pkg::MONTH_W-1:0] month,
                           input logic [gdad_pkg::DAY_W-1:0] day,
                           input logic [gdad_pkg::COUNT_W-1:0] count);
    date_sum_t   item;
    int unsigned gap;
    gap = back_to_back ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_start_year  <= year;
    in_start_month <= month;
    in_start_day   <= day;
    in_days_to_add <= count;
    do @(posedge clk); while (busy !== 1'b0);
    item.year  = year;
    item.month = month;
    item.day   = day;
    item.count = count;
    item.sum   = advance_date(year, month, day, count);
    due_dates.push_back(item);
    dates_sent++;
  endtask

  task automatic random_valid_date(input bit near_end,
                                   output logic [gdad_pkg::YEAR_W-1:0] year,
                                   output logic [gdad_pkg::MONTH_W-1:0] month,
                                   output logic [gdad_pkg::DAY_W-1:0] day);
    year  = near_end
          ? gdad_pkg::YEAR_W'($urandom_range(gdad_pkg::MAX_YEAR - 6, gdad_pkg::MAX_YEAR))
          : gdad_pkg::YEAR_W'($urandom_range(0, gdad_pkg::MAX_YEAR));
    month = gdad_pkg::MONTH_W'($urandom_range(gdad_pkg::JANUARY, gdad_pkg::DECEMBER));
    day   = gdad_pkg::DAY_W'($urandom_range(1, month_length(year, month)));
  endtask

  // Counts spread over up to a month, about two years, about 164 years and the full field.
  function automatic logic [gdad_pkg::COUNT_W-1:0] random_count();
    logic [gdad_pkg::COUNT_W-1:0] cnt;
    case ($urandom_range(0, 3))
      0:       cnt = gdad_pkg::COUNT_W'($urandom_range(0, 31));
      1:       cnt = gdad_pkg::COUNT_W'($urandom_range(0, 800));
      2:       cnt = gdad_pkg::COUNT_W'($urandom_range(0, 60000));
      default: cnt = gdad_pkg::COUNT_W'($urandom);
    endcase
    return cnt;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_edge_dates();
    send_date(0, 1, 1, 0);
    send_date(2024, 2, 29, 0);
    send_date(2023, 2, 29, 0);
    send_date(2100, 2, 29, 0);
    send_date(2023, 2, 28, 1);
    send_date(2024, 2, 28, 1);
    send_date(1900, 2, 28, 1);
    send_date(2000, 2, 28, 1);
    send_date(2023, 0, 0, 0);
    send_date(2023, 15, 31, 0);
    send_date(2023, 13, 5, 1);
    send_date(2023, 4, 31, 0);
    send_date(2023, 12, 31, 1);
    send_date(2023, 1, 1, 364);
    send_date(2023, 1, 1, 365);
    send_date(1600, 12, 31, 366);
    send_date(4, 2, 29, 365);
    send_date(0, 1, 1, gdad_pkg::COUNT_MASK);
    send_date(9999, 12, 31, 0);
    send_date(9999, 12, 30, 1);
    send_date(9999, 12, 31, 1);
    send_date(9998, 1, 1, 730);
    send_date(9999, 1, 1, gdad_pkg::COUNT_MASK);
    send_date(10000, 6, 15, 0);
    send_date('1, '1, '1, '1);
  endtask

  task automatic test_valid_dates();
    logic [gdad_pkg::YEAR_W-1:0]  y;
    logic [gdad_pkg::MONTH_W-1:0] m;
    logic [gdad_pkg::DAY_W-1:0]   d;
    repeat (60) begin
      random_valid_date($urandom_range(0, 7) == 0, y, m, d);
      send_date(y, m, d, random_count());
    end
  endtask

  // Counts that land just around a December 31, up to three years past the starting year.
  task automatic test_year_boundaries();
    logic [gdad_pkg::YEAR_W-1:0]  y;
    logic [gdad_pkg::MONTH_W-1:0] m;
    logic [gdad_pkg::DAY_W-1:0]   d;
    int unsigned                  span;
    repeat (20) begin
      random_valid_date($urandom_range(0, 1) == 1, y, m, d);
      span = year_length(y) - day_of_year(y, m, d)
             + $urandom_range(0, 3) * year_length(y + 1) + $urandom_range(0, 2);
      if (span != 0 && $urandom_range(0, 1)) span--;
      send_date(y, m, d, span[gdad_pkg::COUNT_W-1:0]);
    end
  endtask

  // Unconstrained field bits: bad months, bad days and years past the limit.
  task automatic test_raw_fields();
    repeat (25)
      send_date(gdad_pkg::YEAR_W'($urandom), gdad_pkg::MONTH_W'($urandom),
                gdad_pkg::DAY_W'($urandom), gdad_pkg::COUNT_W'($urandom));
  endtask

  task automatic test_back_to_back();
    logic [gdad_pkg::YEAR_W-1:0]  y;
    logic [gdad_pkg::MONTH_W-1:0] m;
    logic [gdad_pkg::DAY_W-1:0]   d;
    back_to_back = 1'b1;
    repeat (15) begin
      random_valid_date(1'b0, y, m, d);
      send_date(y, m, d, random_count());
    end
    back_to_back = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    date_sum_t item;
    string     tag;
    if (rst_n && $isunknown(out_valid)) begin
      report_mismatch("out_valid is unknown");
    end else if (rst_n && out_valid) begin
      if (due_dates.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d-%0d-%0d overflow %0d",
                                  out_result_year, out_result_month, out_result_day,
                                  out_overflow));
      end else begin
        item = due_dates.pop_front();
        dates_checked++;
        if (out_overflow === 1'b1) overflow_seen++;
        tag = $sformatf("%0d-%0d-%0d + %0d:", item.year, item.month, item.day, item.count);
        if (out_result_year !== item.sum.year)
          report_mismatch($sformatf("%s year %0d, expected %0d", tag, out_result_year,
                                    item.sum.year));
        if (out_result_month !== item.sum.month)
          report_mismatch($sformatf("%s month %0d, expected %0d", tag, out_result_month,
                                    item.sum.month));
        if (out_result_day !== item.sum.day)
          report_mismatch($sformatf("%s day %0d, expected %0d", tag, out_result_day,
                                    item.sum.day));
        if (out_overflow !== item.sum.overflow)
          report_mismatch($sformatf("%s overflow %0d, expected %0d", tag, out_overflow,
                                    item.sum.overflow));
      end
    end
  end

  // Watchdog against a hung handshake or a lost result.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still outstanding", cycle_count,
               due_dates.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_start_year  = '0;
    in_start_month = '0;
    in_start_day   = '0;
    in_days_to_add = '0;
    dates_sent     = 0;
    dates_checked  = 0;
    overflow_seen  = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    back_to_back   = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_edge_dates();
    test_valid_dates();
    test_year_boundaries();
    test_raw_fields();
    test_back_to_back();
    start <= 1'b0;

    while (due_dates.size() != 0) @(posedge clk);
    // Any stray strobe after the last transfer would show up here.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d dates through edge, random, year-end, raw-field and back-to-back tests.",
             dates_sent);
    $display("Compared %0d results, %0d of them saturated, %0d mismatches.", dates_checked,
             overflow_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
